>>> src/lbb_pkg.sv
// Package with the word types, operation codes and cost function of the LRU byte budget cache.
`default_nettype none
package lbb_pkg;
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_TRIM   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key_tag;
      logic [11:0] key_chars;
      logic [31:0] tag_id;
      logic        batch_end;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_id;
      logic [23:0] bytes_used;
      logic [10:0] entry_count;
   } rsp_word_type;

   localparam logic [13:0] ENTRY_OVERHEAD = 14'd180;
   localparam logic [31:0] BUDGET_RESET = 32'd1048576;

   function automatic logic [13:0] cost_of(input logic [11:0] chars);
      return ENTRY_OVERHEAD + {1'b0, chars, 1'b0};
   endfunction
endpackage
`default_nettype wire

>>> src/lbb_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
`default_nettype none
module lbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/lru_cache_byte_budget_top.sv
// Top level of the LRU key cache held to a byte budget, with its sequencer and memories.
//
// Channel  Direction  Handshake               Word
// req      in         req_valid / req_stall   lbb_pkg::req_word_type
// rsp      out        rsp_valid / rsp_stall   lbb_pkg::rsp_word_type
// csr      in         csr_wr_en               32-bit byte budget
//
// Lookups and inserts scan the entry memory one slot a cycle, and each evicted entry passes
// through ST_EV_RD and ST_EV_UPD; a trim goes straight to that eviction loop.
// Clear writes every slot of the entry memory to zero; reset runs the same sweep and takes no
// request until it is done. One result is given per request, and a finished result waits in
// the output register while the next request is taken.
`default_nettype none
module lru_cache_byte_budget_top #(
   parameter int CAPACITY  = 1024,
   parameter int KEY_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lbb_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lbb_pkg::rsp_word_type      rsp_word,
   input  wire logic                  csr_wr_en,
   input  wire logic [31:0]           csr_wr_data
);
   import lbb_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int DW = 1 + 12 + KEY_WIDTH + 32;
   localparam int BW_RAW = $clog2(CAPACITY * 8371 + 1);
   localparam int BYTES_W = (BW_RAW > 24) ? BW_RAW : 24;
   localparam int CW_RAW = $clog2(CAPACITY + 1);
   localparam int CNT_W = (CW_RAW > 11) ? CW_RAW : 11;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_CLR     = 10'b00_0000_0010,
      ST_SCAN    = 10'b00_0000_0100,
      ST_HIT_RD  = 10'b00_0000_1000,
      ST_HIT_LNK = 10'b00_0001_0000,
      ST_MTF     = 10'b00_0010_0000,
      ST_EV_RD   = 10'b00_0100_0000,
      ST_EV_UPD  = 10'b00_1000_0000,
      ST_ADD     = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW:0]          scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [AW-1:0]        free_ff, free_in;
   logic                 free_ok_ff, free_ok_in;
   logic [DW-1:0]        hold_ff, hold_in;
   req_word_type         req_ff, req_in;
   logic [AW-1:0]        front_ff, front_in;
   logic [AW-1:0]        back_ff, back_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [31:0]          budget_ff, budget_in;
   logic                 ev_full_ff, ev_full_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic                 hit_ff, hit_in;
   logic [31:0]          found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;

   logic [AW-1:0]        rd_addr;
   logic                 d_we, n_we, o_we;
   logic [AW-1:0]        d_wa, n_wa, o_wa;
   logic [DW-1:0]        d_wd, d_rd;
   logic [AW-1:0]        n_wd, o_wd, n_rd, o_rd;

   logic                 d_valid;
   logic [11:0]          d_chars;
   logic [KEY_WIDTH-1:0] d_key;
   logic                 key_match;
   logic                 insert_op;
   logic                 after_ev;

   lbb_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(rd_addr), .rd_data(d_rd)
   );
   lbb_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_newer_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(rd_addr), .rd_data(n_rd)
   );
   lbb_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_older_ram (
      .clock(clock), .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_addr(rd_addr), .rd_data(o_rd)
   );

   assign d_valid   = d_rd[DW-1];
   assign d_chars   = d_rd[DW-2 -: 12];
   assign d_key     = d_rd[KEY_WIDTH+31:32];
   assign key_match = d_valid && (d_key == req_ff.key_tag[KEY_WIDTH-1:0]);
   assign insert_op = (req_ff.op == OP_INSERT);
   assign after_ev  = insert_op && req_ff.batch_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      free_in      = free_ff;
      free_ok_in   = free_ok_ff;
      hold_in      = hold_ff;
      req_in       = req_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      bytes_in     = bytes_ff;
      count_in     = count_ff;
      budget_in    = csr_wr_en ? csr_wr_data : budget_ff;
      ev_full_in   = ev_full_ff;
      clr_rsp_in   = clr_rsp_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_addr      = scan_ff[AW-1:0];
      d_we = 1'b0; d_wa = scan_ff[AW-1:0]; d_wd = '0;
      n_we = 1'b0; n_wa = front_ff;        n_wd = slot_ff;
      o_we = 1'b0; o_wa = slot_ff;         o_wd = front_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_word;
               scan_in    = '0;
               pend_in    = 1'b0;
               free_ok_in = 1'b0;
               ev_full_in = 1'b0;
               hit_in     = 1'b0;
               found_in   = '0;
               unique case (req_word.op)
                  OP_LOOKUP, OP_INSERT: state_in = ST_SCAN;
                  OP_TRIM:              state_in = ST_EV_RD;
                  OP_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLR;
                  end
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR: begin
            d_we    = 1'b1;
            d_wa    = scan_ff[AW-1:0];
            d_wd    = '0;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == (AW+1)'(CAPACITY - 1)) begin
               front_in = '0;
               back_in  = '0;
               bytes_in = '0;
               count_in = '0;
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_ff < (AW+1)'(CAPACITY)) begin
               rd_addr = scan_ff[AW-1:0];
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
               idx_in  = scan_ff[AW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (key_match) begin
                  slot_in  = idx_ff;
                  hold_in  = d_rd;
                  pend_in  = 1'b0;
                  state_in = ST_HIT_RD;
               end else begin
                  if (!d_valid && !free_ok_ff) begin
                     free_in    = idx_ff;
                     free_ok_in = 1'b1;
                  end
                  if (idx_ff == AW'(CAPACITY - 1)) begin
                     pend_in = 1'b0;
                     if (!insert_op) begin
                        state_in = ST_DONE;
                     end else if (count_ff >= CNT_W'(CAPACITY)) begin
                        ev_full_in = 1'b1;
                        state_in   = ST_EV_RD;
                     end else begin
                        state_in = ST_ADD;
                     end
                  end
               end
            end
         end
         ST_HIT_RD: begin
            rd_addr = slot_ff;
            if (insert_op) begin
               d_we = 1'b1;
               d_wa = slot_ff;
               d_wd = {1'b1, hold_ff[DW-2:32], req_ff.tag_id};
            end else begin
               hit_in   = 1'b1;
               found_in = hold_ff[31:0];
            end
            state_in = ST_HIT_LNK;
         end
         ST_HIT_LNK: begin
            if (slot_ff == front_ff || count_ff < CNT_W'(2)) begin
               state_in = after_ev ? ST_EV_RD : ST_DONE;
            end else begin
               o_we = 1'b1;
               o_wa = n_rd;
               o_wd = o_rd;
               if (slot_ff == back_ff) begin
                  back_in = n_rd;
               end else begin
                  n_we = 1'b1;
                  n_wa = o_rd;
                  n_wd = n_rd;
               end
               state_in = ST_MTF;
            end
         end
         ST_MTF: begin
            o_we     = 1'b1;
            o_wa     = slot_ff;
            o_wd     = front_ff;
            n_we     = 1'b1;
            n_wa     = front_ff;
            n_wd     = slot_ff;
            front_in = slot_ff;
            state_in = after_ev ? ST_EV_RD : ST_DONE;
         end
         ST_EV_RD: begin
            rd_addr = back_ff;
            if (count_ff != '0 && (ev_full_ff || 32'(bytes_ff) > budget_ff)) begin
               state_in = ST_EV_UPD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EV_UPD: begin
            bytes_in = bytes_ff - BYTES_W'(cost_of(d_chars));
            d_we     = 1'b1;
            d_wa     = back_ff;
            d_wd     = '0;
            if (count_ff > CNT_W'(1)) begin
               back_in = n_rd;
            end
            count_in = count_ff - 1'b1;
            if (ev_full_ff) begin
               free_in    = back_ff;
               ev_full_in = 1'b0;
               state_in   = ST_ADD;
            end else begin
               state_in = ST_EV_RD;
            end
         end
         ST_ADD: begin
            d_we = 1'b1;
            d_wa = free_ff;
            d_wd = {1'b1, req_ff.key_chars, req_ff.key_tag[KEY_WIDTH-1:0], req_ff.tag_id};
            if (count_ff == '0) begin
               back_in = free_ff;
            end else begin
               o_we = 1'b1;
               o_wa = free_ff;
               o_wd = front_ff;
               n_we = 1'b1;
               n_wa = front_ff;
               n_wd = free_ff;
            end
            front_in = free_ff;
            count_in = count_ff + 1'b1;
            bytes_in = bytes_ff + BYTES_W'(cost_of(req_ff.key_chars));
            state_in = after_ev ? ST_EV_RD : ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = hit_ff;
               rsp_in.found_id    = found_ff;
               rsp_in.bytes_used  = (bytes_ff > BYTES_W'(24'hFFFFFF)) ? 24'hFFFFFF
                                                                      : bytes_ff[23:0];
               rsp_in.entry_count = (count_ff > CNT_W'(11'h7FF)) ? 11'h7FF : count_ff[10:0];
               clr_rsp_in         = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         free_ok_ff   <= 1'b0;
         front_ff     <= '0;
         back_ff      <= '0;
         bytes_ff     <= '0;
         count_ff     <= '0;
         budget_ff    <= BUDGET_RESET;
         ev_full_ff   <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         free_ok_ff   <= free_ok_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         bytes_ff     <= bytes_in;
         count_ff     <= count_in;
         budget_ff    <= budget_in;
         ev_full_ff   <= ev_full_in;
         clr_rsp_ff   <= clr_rsp_in;
         hit_ff       <= hit_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      free_ff <= free_in;
      hold_ff <= hold_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end
endmodule
`default_nettype wire

>>> src/lbb_check.sv
// Port checker for the LRU byte budget cache and the bind that attaches it to the top level.
`default_nettype none
module lbb_check #(
   parameter int CAPACITY = 1024
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire lbb_pkg::rsp_word_type rsp_word
);
   import lbb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("Stalled result word changed.");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_word.entry_count) <= CAPACITY)
      else $error("Entry count exceeds capacity.");

   a_miss_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |-> rsp_word.found_id == '0)
      else $error("Found id set without a hit.");

   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.entry_count == '0 |-> rsp_word.bytes_used == '0)
      else $error("Bytes used while the store is empty.");
endmodule

bind lru_cache_byte_budget_top lbb_check #(.CAPACITY(CAPACITY)) u_lbb_check (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_word(rsp_word)
);
`default_nettype wire
